// ===== src/csd_shift_add_planner_defines.svh =====
// Assertion macros for the CSD shift/add planner.
`ifndef CSD_SHIFT_ADD_PLANNER_DEFINES_SVH
`define CSD_SHIFT_ADD_PLANNER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csd_shift_add_planner: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CSD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csd_shift_add_planner: next-cycle check failed");

`else

`define CSD_ASSERT_IMP(label, ante, cons)
`define CSD_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/csd_pkg.sv =====
// Shared constants and types of the CSD shift/add planner.
package csd_pkg;

    // Width of the constant that is recoded
    localparam int CONST_WIDTH = 32;
    // Bits needed to name a digit position
    localparam int POS_W = $clog2(CONST_WIDTH);
    // At most this many steps are planned for one constant
    localparam int MAX_STEPS = 16;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    // Widths of the item fields
    localparam int MULT_W = 31;
    localparam int FIELD_POS_W = 5;

    // Step operations
    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2
    } op_t;

    // Recoded digits handed from the recoder to the emitter
    typedef struct packed {
        logic [CONST_WIDTH-1:0] nz;
        logic [CONST_WIDTH-1:0] neg;
        logic [CNT_W-1:0]       count;
    } digits_t;

endpackage

// ===== src/csd_recoder.sv =====
// Bit-serial canonical signed digit recoder, LSB first, one position per cycle.
module csd_recoder import csd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MULT_W-1:0]   multiplier,
    output logic                dig_valid,
    input  logic                dig_ready,
    output digits_t             digits
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                 state_reg,  state_next;
    logic [CONST_WIDTH-1:0] bits_reg,   bits_next;
    logic                   carry_reg,  carry_next;
    logic [CONST_WIDTH-1:0] nz_reg,     nz_next;
    logic [CONST_WIDTH-1:0] neg_reg,    neg_next;
    logic [CNT_W-1:0]       cnt_reg,    cnt_next;
    logic [POS_W-1:0]       idx_reg,    idx_next;

    logic b, bn, nz, neg, cn;

    // One recoding step on the current low bit
    assign b   = bits_reg[0];
    assign bn  = bits_reg[1];
    assign cn  = (b & bn) | (b & carry_reg) | (bn & carry_reg);
    assign nz  = b ^ carry_reg;
    assign neg = nz & bn;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        bits_next  = bits_reg;
        carry_next = carry_reg;
        nz_next    = nz_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bits_next  = CONST_WIDTH'(multiplier);
                    carry_next = 1'b0;
                    cnt_next   = '0;
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                bits_next  = {1'b0, bits_reg[CONST_WIDTH-1:1]};
                carry_next = cn;
                nz_next    = {nz, nz_reg[CONST_WIDTH-1:1]};
                neg_next   = {neg, neg_reg[CONST_WIDTH-1:1]};
                if (nz && cnt_reg != CNT_W'(MAX_STEPS))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == POS_W'(CONST_WIDTH - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (dig_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bits_reg  <= '0;
            carry_reg <= 1'b0;
            nz_reg    <= '0;
            neg_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bits_reg  <= bits_next;
            carry_reg <= carry_next;
            nz_reg    <= nz_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign dig_valid    = (state_reg == ST_HOLD);
    assign digits.nz    = nz_reg;
    assign digits.neg   = neg_reg;
    assign digits.count = cnt_reg;

endmodule

// ===== src/csd_emitter.sv =====
// Serial MSB-first digit scanner that issues one shift/add step per nonzero digit.
module csd_emitter import csd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   dig_valid,
    output logic                   dig_ready,
    input  digits_t                digits,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   shift_right,
    output logic [FIELD_POS_W-1:0] shift_count,
    output logic [1:0]             operation,
    output logic [FIELD_POS_W-1:0] digit_position,
    output logic                   last,
    output logic                   busy
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                 state_reg,   state_next;
    logic [CONST_WIDTH-1:0] nz_reg,      nz_next;
    logic [CONST_WIDTH-1:0] neg_reg,     neg_next;
    logic [CNT_W-1:0]       remain_reg,  remain_next;
    logic [POS_W-1:0]       pos_reg,     pos_next;
    logic [POS_W-1:0]       prev_reg,    prev_next;
    logic                   first_reg,   first_next;

    logic                   ov_reg,      ov_next;
    logic                   sr_reg,      sr_next;
    logic [FIELD_POS_W-1:0] amt_reg,     amt_next;
    op_t                    op_reg,      op_next;
    logic [FIELD_POS_W-1:0] dpos_reg,    dpos_next;
    logic                   last_reg,    last_next;

    logic top_nz, top_neg, can_load;

    assign top_nz   = nz_reg[CONST_WIDTH-1];
    assign top_neg  = neg_reg[CONST_WIDTH-1];
    assign can_load = !ov_reg || !out_stall;

    // Scan control and step formation
    always_comb
    begin
        state_next  = state_reg;
        nz_next     = nz_reg;
        neg_next    = neg_reg;
        remain_next = remain_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        first_next  = first_reg;
        ov_next     = ov_reg && out_stall;
        sr_next     = sr_reg;
        amt_next    = amt_reg;
        op_next     = op_reg;
        dpos_next   = dpos_reg;
        last_next   = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (dig_valid)
                begin
                    nz_next     = digits.nz;
                    neg_next    = digits.neg;
                    remain_next = digits.count;
                    pos_next    = POS_W'(CONST_WIDTH - 1);
                    prev_next   = '0;
                    first_next  = 1'b1;
                    if (digits.count != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!top_nz || can_load)
                begin
                    nz_next  = {nz_reg[CONST_WIDTH-2:0], 1'b0};
                    neg_next = {neg_reg[CONST_WIDTH-2:0], 1'b0};
                    pos_next = pos_reg - 1'b1;
                end
                // Nonzero digit: issue a step once the output register is free
                if (top_nz && can_load)
                begin
                    ov_next = 1'b1;
                    if (first_reg)
                    begin
                        // First step: shift from position zero, move into result
                        sr_next  = (pos_reg == '0);
                        amt_next = FIELD_POS_W'(pos_reg);
                        op_next  = OP_MOVE;
                    end
                    else
                    begin
                        sr_next  = 1'b1;
                        amt_next = FIELD_POS_W'(prev_reg - pos_reg);
                        op_next  = top_neg ? OP_SUB : OP_ADD;
                    end
                    dpos_next   = FIELD_POS_W'(pos_reg);
                    last_next   = (remain_reg == CNT_W'(1));
                    prev_next   = pos_reg;
                    first_next  = 1'b0;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, scan registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            nz_reg     <= '0;
            neg_reg    <= '0;
            remain_reg <= '0;
            pos_reg    <= '0;
            prev_reg   <= '0;
            first_reg  <= 1'b1;
            ov_reg     <= 1'b0;
            sr_reg     <= 1'b0;
            amt_reg    <= '0;
            op_reg     <= OP_MOVE;
            dpos_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nz_reg     <= nz_next;
            neg_reg    <= neg_next;
            remain_reg <= remain_next;
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            first_reg  <= first_next;
            ov_reg     <= ov_next;
            sr_reg     <= sr_next;
            amt_reg    <= amt_next;
            op_reg     <= op_next;
            dpos_reg   <= dpos_next;
            last_reg   <= last_next;
        end
    end

    assign dig_ready      = (state_reg == ST_IDLE);
    assign busy           = (state_reg != ST_IDLE) || ov_reg;
    assign out_valid      = ov_reg;
    assign shift_right    = sr_reg;
    assign shift_count    = amt_reg;
    assign operation      = op_reg;
    assign digit_position = dpos_reg;
    assign last           = last_reg;

endmodule

// ===== src/csd_shift_add_planner.sv =====
// Top level of the CSD shift/add planner: recoder, emitter and checks.
//
// Each input item is a positive constant; the block recodes it into canonical
// signed digits and issues one output item per nonzero digit, most significant
// first, telling how to shift the working multiplicand and whether to move,
// add or subtract it; the final item of a constant has last set, and a zero
// constant gives no items. Recoding runs one bit position per cycle through a
// shift register before the digits are handed over; the emitter then walks
// the 32 digit positions one per cycle and stops after the last nonzero
// digit, holding while out_stall is high. The recoder takes the next
// constant while the emitter still works on the previous one.
`include "csd_shift_add_planner_defines.svh"

module csd_shift_add_planner import csd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [MULT_W-1:0]      multiplier,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   shift_right,
    output logic [FIELD_POS_W-1:0] shift_count,
    output logic [1:0]             operation,
    output logic [FIELD_POS_W-1:0] digit_position,
    output logic                   last
);

    logic    dig_valid;
    logic    dig_ready;
    digits_t digits;
    logic    em_busy;

    // Serial recoder
    csd_recoder u_recoder
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .multiplier (multiplier),
        .dig_valid  (dig_valid),
        .dig_ready  (dig_ready),
        .digits     (digits)
    );

    // Digit scanner and output register
    csd_emitter u_emitter
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .dig_valid      (dig_valid),
        .dig_ready      (dig_ready),
        .digits         (digits),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .shift_right    (shift_right),
        .shift_count    (shift_count),
        .operation      (operation),
        .digit_position (digit_position),
        .last           (last),
        .busy           (em_busy)
    );

    // An accepted constant keeps the input stalled while it is recoded
    `CSD_ASSERT_NXT(a_stall_after_accept, in_valid && !in_stall, in_stall)
    // Every step after the first shifts right
    `CSD_ASSERT_IMP(a_later_steps_shift_right, out_valid && operation != OP_MOVE, shift_right)
    // A taken step that is not the last leaves the emitter working on the constant
    `CSD_ASSERT_NXT(a_more_steps_pending, out_valid && !out_stall && !last, em_busy)

endmodule
